/* hw/rtl/uart_command_reply_engine_macros.svh */
// Assertion macros for the UART command/reply engine.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef UART_COMMAND_REPLY_ENGINE_MACROS_SVH
`define UART_COMMAND_REPLY_ENGINE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define UCRE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define UCRE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/ucre_pkg.sv */
// Shared types and constants of the UART command/reply engine.
// Used by the front, queue, back and top-level files; depends on nothing.
package ucre_pkg;

	// Input selector codes
	localparam logic [1:0] FN_CMD  = 2'd0;
	localparam logic [1:0] FN_RX   = 2'd1;
	localparam logic [1:0] FN_TICK = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_TX      = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_STATUS  = 2'd2;

	// Status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_TIMEOUT = 3'd1;
	localparam logic [2:0] ST_CSUM    = 3'd2;
	localparam logic [2:0] ST_NOACK   = 3'd3;
	localparam logic [2:0] ST_TOOLONG = 3'd4;

	// Register indexes
	localparam logic [1:0] REG_REPLY_LENGTH  = 2'd0;
	localparam logic [1:0] REG_ACK_MODE      = 2'd1;
	localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

	// Register reset values
	localparam logic [5:0]  REPLY_LENGTH_RST  = 6'd2;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd500;

	// Two-byte acknowledge
	localparam logic [7:0] ACK_FIRST  = 8'h40;
	localparam logic [7:0] ACK_SECOND = 8'h30;

	// Field widths that cover the whole parameter ranges
	localparam int JOB_CNT_W = 6;
	localparam int ADDR_W    = 6;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		JOB_CMD,
		JOB_STATUS,
		JOB_REPLY
	} job_kind_t;

	// One unit of work for the back end
	typedef struct packed {
		job_kind_t            kind;
		logic [2:0]           status;
		logic [JOB_CNT_W-1:0] cnt;     // command bytes, or reply payload length
		logic                 ack;
	} job_t;

	typedef struct packed {
		logic        en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]  data;
	} wr_t;

	typedef struct packed {
		logic [5:0]  reply_length;
		logic        ack_mode;
		logic [15:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic cmd_busy;
		logic rep_busy;
	} busy_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic has_cmd;
		logic has_reply;
	} q_stat_t;

	typedef struct packed {
		logic waiting;
	} front_stat_t;

endpackage

/* hw/rtl/ucre_queue.sv */
// Two-entry job queue between the front end and the back end.
// Depends on ucre_pkg for the job type and queue status struct.
module ucre_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ucre_pkg::job_t   push_job,
	input  logic             pop,
	output ucre_pkg::job_t   head,
	output ucre_pkg::q_stat_t stat
);
	import ucre_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	job_t                   ent_q [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] vld_q;
	logic [PW-1:0]          wr_ptr_q;
	logic [PW-1:0]          rd_ptr_q;

	assign head = ent_q[rd_ptr_q];

	// Occupancy and kinds held, for the store-hazard checks
	always_comb begin
		stat.full      = &vld_q;
		stat.empty     = ~|vld_q;
		stat.has_cmd   = 1'b0;
		stat.has_reply = 1'b0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (vld_q[i] && ent_q[i].kind == JOB_CMD) stat.has_cmd = 1'b1;
			if (vld_q[i] && ent_q[i].kind == JOB_REPLY) stat.has_reply = 1'b1;
		end
	end

	// Entry payload
	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= push_job;
	end

	// Pointers and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (pop) begin
				vld_q[rd_ptr_q] <= 1'b0;
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push) begin
				vld_q[wr_ptr_q] <= 1'b1;
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/ucre_front.sv */
// Front end: accepts input transfers, tracks command/reply/timeout state,
// writes the stores and queues jobs. Depends on ucre_pkg.
module ucre_front #(
	parameter int MAX_CMD   = 5,
	parameter int MAX_REPLY = 36
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            func,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	input  ucre_pkg::cfg_t        cfg,
	input  ucre_pkg::busy_t       haz,
	input  logic                  q_full,
	output logic                  push,
	output ucre_pkg::job_t        job,
	output ucre_pkg::wr_t         cmd_wr,
	output ucre_pkg::wr_t         rep_wr,
	output ucre_pkg::front_stat_t stat
);
	import ucre_pkg::*;

	localparam int CCW = $clog2(MAX_CMD + 1);
	localparam int RCW = $clog2(MAX_REPLY + 2);

	logic [CCW-1:0] cmd_cnt_q, cmd_cnt_n;
	logic           ovf_q, ovf_n;
	logic [RCW-1:0] rep_cnt_q, rep_cnt_n, rep_sum;
	logic           waiting_q, waiting_n;
	logic [15:0]    tick_q, tick_n, tick_inc, limit;
	logic [JOB_CNT_W-1:0] plen;
	logic           too_long;
	logic           accept;

	// Hold off on a full queue, or an item whose store a queued/active job reads
	assign in_ready = !q_full
		&& !(func == FN_CMD && !waiting_q && haz.cmd_busy)
		&& !(func == FN_RX && waiting_q && haz.rep_busy);
	assign accept = in_valid && in_ready;
	assign stat.waiting = waiting_q;

	// Payload length in force: ack replies are two bytes, else saturated register
	always_comb begin
		if (cfg.ack_mode) plen = JOB_CNT_W'(2);
		else if (cfg.reply_length > 6'(MAX_REPLY)) plen = JOB_CNT_W'(MAX_REPLY);
		else plen = JOB_CNT_W'(cfg.reply_length);
	end

	assign tick_inc = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;
	assign limit    = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
	assign too_long = ovf_q || (cmd_cnt_q == CCW'(MAX_CMD));
	assign rep_sum  = RCW'(rep_cnt_q + 1'b1);

	// Item classification and next state
	always_comb begin
		cmd_cnt_n = cmd_cnt_q;
		ovf_n     = ovf_q;
		rep_cnt_n = rep_cnt_q;
		waiting_n = waiting_q;
		tick_n    = tick_q;
		push      = 1'b0;
		job       = '{kind: JOB_STATUS, status: ST_OK, cnt: '0, ack: 1'b0};
		cmd_wr    = '{en: 1'b0, addr: ADDR_W'(cmd_cnt_q), data: data_byte};
		rep_wr    = '{en: 1'b0, addr: ADDR_W'(rep_cnt_q), data: data_byte};
		if (accept) begin
			unique case (func)
				FN_CMD: begin
					if (!waiting_q) begin
						cmd_wr.en = !too_long;
						if (last_byte) begin
							push = 1'b1;
							if (too_long) begin
								job.status = ST_TOOLONG;
							end else begin
								job.kind  = JOB_CMD;
								job.cnt   = JOB_CNT_W'(cmd_cnt_q + 1'b1);
								waiting_n = 1'b1;
								rep_cnt_n = '0;
								tick_n    = '0;
							end
							cmd_cnt_n = '0;
							ovf_n     = 1'b0;
						end else if (too_long) begin
							ovf_n = 1'b1;
						end else begin
							cmd_cnt_n = CCW'(cmd_cnt_q + 1'b1);
						end
					end
				end
				FN_RX: begin
					if (waiting_q) begin
						rep_wr.en = (rep_cnt_q <= RCW'(MAX_REPLY));
						if (8'(rep_sum) > 8'(plen)) begin
							push      = 1'b1;
							job.kind  = JOB_REPLY;
							job.cnt   = plen;
							job.ack   = cfg.ack_mode;
							waiting_n = 1'b0;
							rep_cnt_n = '0;
							tick_n    = '0;
						end else begin
							rep_cnt_n = rep_sum;
						end
					end
				end
				FN_TICK: begin
					if (waiting_q) begin
						if (tick_inc >= limit) begin
							push       = 1'b1;
							job.status = ST_TIMEOUT;
							waiting_n  = 1'b0;
							rep_cnt_n  = '0;
							tick_n     = '0;
						end else begin
							tick_n = tick_inc;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Front state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_cnt_q <= '0;
			ovf_q     <= 1'b0;
			rep_cnt_q <= '0;
			waiting_q <= 1'b0;
			tick_q    <= '0;
		end else begin
			cmd_cnt_q <= cmd_cnt_n;
			ovf_q     <= ovf_n;
			rep_cnt_q <= rep_cnt_n;
			waiting_q <= waiting_n;
			tick_q    <= tick_n;
		end
	end

endmodule

/* hw/rtl/ucre_back.sv */
// Back end: holds the command and reply stores, runs queued jobs and drives
// the output register. Depends on ucre_pkg.
module ucre_back #(
	parameter int MAX_CMD   = 5,
	parameter int MAX_REPLY = 36
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ucre_pkg::wr_t   cmd_wr,
	input  ucre_pkg::wr_t   rep_wr,
	input  ucre_pkg::job_t  head,
	input  logic            q_empty,
	output logic            pop,
	output ucre_pkg::busy_t stat,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [1:0]      kind,
	output logic [7:0]      data_out,
	output logic [2:0]      status,
	output logic            last
);
	import ucre_pkg::*;

	localparam int CAW    = (MAX_CMD > 1) ? $clog2(MAX_CMD) : 1;
	localparam int RDEPTH = MAX_REPLY + 1;
	localparam int RAW    = $clog2(RDEPTH);

	typedef enum logic [2:0] {
		B_IDLE,
		B_CMD,
		B_SUM,
		B_STAT,
		B_CHK_RD,
		B_CHK_USE,
		B_PAY_RD,
		B_PAY_OUT
	} bstate_t;

	bstate_t              state_q;
	logic [JOB_CNT_W-1:0] idx_q;
	logic [JOB_CNT_W-1:0] cnt_q;
	logic                 ack_q;
	logic                 ack_ok_q;
	logic [2:0]           stat_q;
	logic [7:0]           xor_q;
	logic                 out_valid_q;
	logic [1:0]           kind_q;
	logic [7:0]           data_q;
	logic [2:0]           status_q;
	logic                 last_q;

	logic [7:0] cmd_mem_q [MAX_CMD];
	logic [7:0] rep_mem [RDEPTH];
	logic [7:0] rdata_q;
	logic [7:0] cmd_rd;
	logic       out_free;
	logic       out_load;

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign data_out  = data_q;
	assign status    = status_q;
	assign last      = last_q;

	assign out_free = !out_valid_q || out_ready;
	assign pop      = (state_q == B_IDLE) && !q_empty;
	assign cmd_rd   = cmd_mem_q[idx_q[CAW-1:0]];

	// Output register takes a new transfer this cycle
	assign out_load = out_free && ((state_q == B_CMD) || (state_q == B_SUM)
		|| (state_q == B_STAT) || (state_q == B_PAY_OUT));

	// Stores still being read by the active job
	assign stat.cmd_busy = (state_q == B_CMD) || (state_q == B_SUM);
	assign stat.rep_busy = (state_q == B_CHK_RD) || (state_q == B_CHK_USE)
		|| (state_q == B_PAY_RD) || (state_q == B_PAY_OUT);

	// Command store
	always_ff @(posedge clk) begin
		if (cmd_wr.en) cmd_mem_q[cmd_wr.addr[CAW-1:0]] <= cmd_wr.data;
	end

	// Reply memory, registered read at the job index
	always_ff @(posedge clk) begin
		if (rep_wr.en) rep_mem[rep_wr.addr[RAW-1:0]] <= rep_wr.data;
		rdata_q <= rep_mem[idx_q[RAW-1:0]];
	end

	// Job sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			idx_q       <= '0;
			cnt_q       <= '0;
			ack_q       <= 1'b0;
			ack_ok_q    <= 1'b0;
			stat_q      <= ST_OK;
			xor_q       <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_TX;
			data_q      <= '0;
			status_q    <= ST_OK;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load) out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						idx_q    <= '0;
						xor_q    <= '0;
						cnt_q    <= head.cnt;
						ack_q    <= head.ack;
						ack_ok_q <= 1'b0;
						stat_q   <= head.status;
						unique case (head.kind)
							JOB_CMD:    state_q <= B_CMD;
							JOB_REPLY:  state_q <= B_CHK_RD;
							JOB_STATUS: state_q <= B_STAT;
							default:    state_q <= B_STAT;
						endcase
					end
				end
				B_CMD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_TX;
						data_q      <= cmd_rd;
						status_q    <= ST_OK;
						last_q      <= 1'b0;
						xor_q       <= xor_q ^ cmd_rd;
						if (idx_q == cnt_q - 1'b1) state_q <= B_SUM;
						else idx_q <= idx_q + 1'b1;
					end
				end
				B_SUM: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_TX;
						data_q      <= xor_q;
						status_q    <= ST_OK;
						last_q      <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				B_STAT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_STATUS;
						data_q      <= '0;
						status_q    <= stat_q;
						last_q      <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				B_CHK_RD: state_q <= B_CHK_USE;
				// Checksum pass: fold payload bytes, compare with the byte after them
				B_CHK_USE: begin
					if (idx_q != cnt_q) begin
						xor_q <= xor_q ^ rdata_q;
						if (idx_q == '0) ack_ok_q <= (rdata_q == ACK_FIRST);
						if (idx_q == JOB_CNT_W'(1)) ack_ok_q <= ack_ok_q && (rdata_q == ACK_SECOND);
						idx_q   <= idx_q + 1'b1;
						state_q <= B_CHK_RD;
					end else if (xor_q != rdata_q) begin
						stat_q  <= ST_CSUM;
						state_q <= B_STAT;
					end else if (ack_q) begin
						stat_q  <= ack_ok_q ? ST_OK : ST_NOACK;
						state_q <= B_STAT;
					end else begin
						stat_q  <= ST_OK;
						idx_q   <= '0;
						state_q <= (cnt_q == '0) ? B_STAT : B_PAY_RD;
					end
				end
				B_PAY_RD: state_q <= B_PAY_OUT;
				B_PAY_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_PAYLOAD;
						data_q      <= rdata_q;
						status_q    <= ST_OK;
						last_q      <= 1'b0;
						if (idx_q == cnt_q - 1'b1) begin
							state_q <= B_STAT;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= B_PAY_RD;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/uart_command_reply_engine.sv */
// UART command/reply engine: a front end classifies input transfers and keeps
// the command/reply/timeout state, a two-entry job queue decouples it from a
// back end that transmits commands and checks and releases replies. A command
// of n bytes gives n+1 output transfers at one per cycle while the output is
// not stalled. A reply of L payload bytes is checked through the registered
// read port of the reply memory, then released as its payload bytes and a
// status transfer, or as a status transfer alone in ack mode or on a bad
// checksum. Input is held off while the job queue is full, or when the item
// would write a store (command or reply) that a queued or active job still
// reads.
// Depends on ucre_pkg, ucre_front, ucre_queue, ucre_back and the macro header.
`include "uart_command_reply_engine_macros.svh"

module uart_command_reply_engine #(
	parameter int MAX_COMMAND_BYTES = 5,
	parameter int MAX_REPLY_BYTES   = 36
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] data_byte
	input  logic [1:0]  s_tuser,    // [1:0] func
	input  logic        s_tlast,    // last_byte
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [7:0] data_out, [10:8] status, [15:11] zero
	output logic [1:0]  m_tuser,    // [1:0] kind
	output logic        m_tlast,    // last
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ucre_pkg::*;

	logic [5:0]  reply_length_q;
	logic        ack_mode_q;
	logic [15:0] timeout_ticks_q;

	cfg_t        cfg;
	busy_t       haz;
	busy_t       bstat;
	q_stat_t     qstat;
	front_stat_t fstat;
	job_t        push_job;
	job_t        head;
	wr_t         cmd_wr;
	wr_t         rep_wr;
	logic        push;
	logic        pop;
	logic [7:0]  data_out;
	logic [2:0]  status;

	// Configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_length_q  <= REPLY_LENGTH_RST;
			ack_mode_q      <= 1'b0;
			timeout_ticks_q <= TIMEOUT_TICKS_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_REPLY_LENGTH:  reply_length_q  <= pwdata[5:0];
				REG_ACK_MODE:      ack_mode_q      <= pwdata[0];
				REG_TIMEOUT_TICKS: timeout_ticks_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_REPLY_LENGTH:  prdata = {26'd0, reply_length_q};
			REG_ACK_MODE:      prdata = {31'd0, ack_mode_q};
			REG_TIMEOUT_TICKS: prdata = {16'd0, timeout_ticks_q};
			default:           prdata = '0;
		endcase
	end

	assign cfg = '{reply_length: reply_length_q, ack_mode: ack_mode_q,
		timeout_ticks: timeout_ticks_q};

	// Store hazards: queued or active jobs still reading a store
	assign haz.cmd_busy = bstat.cmd_busy || qstat.has_cmd;
	assign haz.rep_busy = bstat.rep_busy || qstat.has_reply;

	ucre_front #(
		.MAX_CMD   (MAX_COMMAND_BYTES),
		.MAX_REPLY (MAX_REPLY_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.func      (s_tuser),
		.data_byte (s_tdata),
		.last_byte (s_tlast),
		.cfg       (cfg),
		.haz       (haz),
		.q_full    (qstat.full),
		.push      (push),
		.job       (push_job),
		.cmd_wr    (cmd_wr),
		.rep_wr    (rep_wr),
		.stat      (fstat)
	);

	ucre_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (qstat)
	);

	ucre_back #(
		.MAX_CMD   (MAX_COMMAND_BYTES),
		.MAX_REPLY (MAX_REPLY_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_wr    (cmd_wr),
		.rep_wr    (rep_wr),
		.head      (head),
		.q_empty   (qstat.empty),
		.pop       (pop),
		.stat      (bstat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.kind      (m_tuser),
		.data_out  (data_out),
		.status    (status),
		.last      (m_tlast)
	);

	assign m_tdata = {5'd0, status, data_out};

	// Checks
	`UCRE_ASSERT_IMP(a_rep_store_safe, clk, arst_n, rep_wr.en, !haz.rep_busy, "reply store written while read")
	`UCRE_ASSERT_IMP(a_cmd_store_safe, clk, arst_n, cmd_wr.en, !haz.cmd_busy, "command store written while read")
	`UCRE_ASSERT_NXT(a_cmd_waits, clk, arst_n, push && push_job.kind == JOB_CMD, fstat.waiting, "no wait after command")
	`UCRE_ASSERT_IMP(a_status_last, clk, arst_n, m_tvalid && m_tuser == KIND_STATUS, m_tlast, "status not last")

endmodule

/* tb/ucre_scoreboard.sv */
`timescale 1ns / 1ps
// Scoreboard for the UART command/reply engine: follows the register port and both
// streams, predicts every result transfer and compares it with what the block emits.
// Depends on ucre_pkg.
module ucre_scoreboard
	import ucre_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          outstanding
);

	localparam int CMD_SLOTS = 5;
	localparam int REPLY_CAP = 36;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [2:0] status;
		logic       last;
	} engine_out_t;

	engine_out_t owed_results[$];
	engine_out_t got;
	engine_out_t want;

	// register copies
	int reply_len;
	logic ack_on;
	int timeout_limit;

	// engine state
	logic [7:0] cmd_bytes [CMD_SLOTS];
	int cmd_count;
	logic cmd_overflow;
	logic [7:0] reply_bytes [REPLY_CAP + 1];
	int reply_count;
	logic awaiting_reply;
	int tick_count;

	function void owe(input logic [1:0] k, input logic [7:0] d, input logic [2:0] st,
			input logic l);
		owed_results.push_back('{kind: k, data: d, status: st, last: l});
	endfunction

	function void drop_reply();
		awaiting_reply = 1'b0;
		reply_count = 0;
		tick_count = 0;
	endfunction

	// Work out the result transfers caused by one input transfer
	function void advance_engine(input logic [1:0] fn, input logic [7:0] b, input logic lb);
		int i;
		int plen;
		int lim;
		logic [7:0] x;
		x = 8'h00;
		case (fn)
			FN_CMD: begin
				if (!awaiting_reply) begin
					if (cmd_count < CMD_SLOTS) begin
						cmd_bytes[cmd_count] = b;
						cmd_count++;
					end else begin
						cmd_overflow = 1'b1;
					end
					if (lb) begin
						if (cmd_overflow) begin
							owe(KIND_STATUS, 8'h00, ST_TOOLONG, 1'b1);
						end else begin
							for (i = 0; i < cmd_count; i++) begin
								x ^= cmd_bytes[i];
								owe(KIND_TX, cmd_bytes[i], ST_OK, 1'b0);
							end
							owe(KIND_TX, x, ST_OK, 1'b1);
							awaiting_reply = 1'b1;
							reply_count = 0;
							tick_count = 0;
						end
						cmd_count = 0;
						cmd_overflow = 1'b0;
					end
				end
			end
			FN_RX: begin
				if (awaiting_reply) begin
					if (reply_count <= REPLY_CAP)
						reply_bytes[reply_count] = b;
					reply_count++;
					// length in force at this byte; ack mode always expects two
					plen = ack_on ? 2 : (reply_len > REPLY_CAP ? REPLY_CAP : reply_len);
					if (reply_count >= plen + 1) begin
						for (i = 0; i < plen; i++)
							x ^= reply_bytes[i];
						if (x != reply_bytes[plen]) begin
							owe(KIND_STATUS, 8'h00, ST_CSUM, 1'b1);
						end else if (ack_on) begin
							if (reply_bytes[0] == ACK_FIRST && reply_bytes[1] == ACK_SECOND)
								owe(KIND_STATUS, 8'h00, ST_OK, 1'b1);
							else
								owe(KIND_STATUS, 8'h00, ST_NOACK, 1'b1);
						end else begin
							for (i = 0; i < plen; i++)
								owe(KIND_PAYLOAD, reply_bytes[i], ST_OK, 1'b0);
							owe(KIND_STATUS, 8'h00, ST_OK, 1'b1);
						end
						drop_reply();
					end
				end
			end
			FN_TICK: begin
				if (awaiting_reply) begin
					if (tick_count < 65535)
						tick_count++;
					lim = (timeout_limit == 0) ? 1 : timeout_limit;
					if (tick_count >= lim) begin
						owe(KIND_STATUS, 8'h00, ST_TIMEOUT, 1'b1);
						drop_reply();
					end
				end
			end
			default: ;
		endcase
	endfunction

	// Follow register writes and both streams at every rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_len = int'(REPLY_LENGTH_RST);
			ack_on = 1'b0;
			timeout_limit = int'(TIMEOUT_TICKS_RST);
			cmd_count = 0;
			cmd_overflow = 1'b0;
			drop_reply();
			owed_results.delete();
			mismatches = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_REPLY_LENGTH:  reply_len = int'(pwdata[5:0]);
					REG_ACK_MODE:      ack_on = pwdata[0];
					REG_TIMEOUT_TICKS: timeout_limit = int'(pwdata[15:0]);
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				advance_engine(s_tuser, s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				got = '{kind: m_tuser, data: m_tdata[7:0], status: m_tdata[10:8], last: m_tlast};
				if (owed_results.size() == 0) begin
					$display("%0t: unexpected result: kind %0d data %02h status %0d last %0d",
						$time, got.kind, got.data, got.status, got.last);
					mismatches++;
				end else begin
					want = owed_results.pop_front();
					if (got != want || m_tdata[15:11] != 5'd0) begin
						$display({"%0t: result mismatch: expected kind %0d data %02h status %0d",
							" last %0d pad 0, got kind %0d data %02h status %0d last %0d pad %0h"},
							$time, want.kind, want.data, want.status, want.last,
							got.kind, got.data, got.status, got.last, m_tdata[15:11]);
						mismatches++;
					end
				end
			end
		end
		outstanding = owed_results.size();
	end

endmodule

/* tb/tb_uart_command_reply_engine.sv */
`timescale 1ns / 1ps
// Testbench top for the UART command/reply engine: clock, reset, register writes and
// directed plus random stream traffic; checking is done by ucre_scoreboard.
// Depends on ucre_pkg, uart_command_reply_engine and ucre_scoreboard.
module tb_uart_command_reply_engine;
	import ucre_pkg::*;

	localparam logic [1:0] FN_UNUSED = 2'd3;
	localparam int CMD_SLOTS    = 5;
	localparam int REPLY_CAP    = 36;
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT  = 600000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int mismatches;
	int outstanding;

	// stimulus bookkeeping
	int cur_len;
	int cur_ack;
	int cur_tmo;
	int useful_items;
	logic [7:0] reply_frame[$];
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int stall_hold = 0;
	int pick;

	uart_command_reply_engine dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	ucre_scoreboard watch (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Result-side stalls: mostly short, a few long, none in steady phases
	always @(negedge clk) begin
		if (rx_steady) begin
			m_tready <= 1'b1;
		end else if (stall_hold > 0) begin
			stall_hold--;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				m_tready <= 1'b1;
				stall_hold = $urandom_range(0, 4);
			end else if (pick < 93) begin
				m_tready <= 1'b0;
				stall_hold = $urandom_range(0, 2);
			end else begin
				m_tready <= 1'b0;
				stall_hold = $urandom_range(8, 40);
			end
		end
	end

	// Watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	// One input transfer, after a random gap; returns at the next falling edge
	task automatic send_item(input logic [1:0] fn, input logic [7:0] b, input logic lb);
		int gap;
		int r;
		gap = 0;
		r = $urandom_range(0, 99);
		if (!tx_steady && r >= 55)
			gap = (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= b;
		s_tlast <= lb;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apply_setting(input int len, input int ack, input int tmo);
		write_reg(REG_REPLY_LENGTH, 32'(len));
		write_reg(REG_ACK_MODE, 32'(ack));
		write_reg(REG_TIMEOUT_TICKS, 32'(tmo));
		cur_len = len;
		cur_ack = ack;
		cur_tmo = tmo;
	endtask

	// Wait until every predicted result is out, then let the block go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Send reply_frame as received bytes, with optional ticks and stray command bytes
	task automatic send_reply(input int tick_budget, input bit noisy);
		int i;
		for (i = 0; i < reply_frame.size(); i++) begin
			if (tick_budget > 0 && $urandom_range(0, 7) == 0) begin
				send_item(FN_TICK, 8'($urandom), 1'($urandom));
				tick_budget--;
			end
			if (noisy && $urandom_range(0, 19) == 0)
				send_item(FN_CMD, 8'($urandom), 1'($urandom));
			send_item(FN_RX, reply_frame[i], 1'($urandom));
			useful_items++;
		end
	endtask

	// One command and, mostly, its reply; sometimes idle noise or a timeout
	task automatic run_exchange();
		int r;
		int ncmd;
		int plen;
		int limit;
		int i;
		logic [7:0] csum;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			// traffic while idle is dropped
			repeat ($urandom_range(1, 3))
				send_item(2'($urandom_range(FN_RX, FN_UNUSED)), 8'($urandom), 1'($urandom));
			return;
		end
		ncmd = ($urandom_range(0, 9) == 0) ? $urandom_range(CMD_SLOTS + 1, CMD_SLOTS + 4)
			: $urandom_range(1, CMD_SLOTS);
		for (i = 0; i < ncmd; i++) begin
			send_item(FN_CMD, 8'($urandom), i == ncmd - 1);
			useful_items++;
		end
		if (ncmd > CMD_SLOTS)
			return;
		plen = (cur_ack != 0) ? 2 : (cur_len > REPLY_CAP ? REPLY_CAP : cur_len);
		limit = (cur_tmo == 0) ? 1 : cur_tmo;
		reply_frame.delete();
		if ($urandom_range(0, 99) < 10 && limit <= 150) begin
			// partial reply, then the timer runs out
			repeat ($urandom_range(0, plen)) reply_frame.push_back(8'($urandom));
			send_reply(0, 1'b1);
			repeat (limit) begin
				send_item(FN_TICK, 8'($urandom), 1'($urandom));
				useful_items++;
			end
			return;
		end
		csum = 8'h00;
		for (i = 0; i < plen; i++) begin
			if (cur_ack != 0 && $urandom_range(0, 2) != 0)
				reply_frame.push_back((i == 0) ? ACK_FIRST : ACK_SECOND);
			else
				reply_frame.push_back(8'($urandom));
			csum ^= reply_frame[i];
		end
		if ($urandom_range(0, 9) == 0)
			csum ^= 8'h01 << $urandom_range(0, 7);
		reply_frame.push_back(csum);
		send_reply(limit - 1, 1'b1);
	endtask

	task automatic run_phase(input int len, input int ack, input int tmo, input int exchanges);
		settle();
		tx_steady = ($urandom_range(0, 3) == 0);
		rx_steady = ($urandom_range(0, 3) == 0);
		apply_setting(len, ack, tmo);
		repeat (exchanges) run_exchange();
	endtask

	initial begin
		int i;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		s_tuser <= FN_CMD;
		s_tlast <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 4'd0;
		pwdata <= 32'd0;
		cur_len = int'(REPLY_LENGTH_RST);
		cur_ack = 0;
		cur_tmo = int'(TIMEOUT_TICKS_RST);
		useful_items = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// idle traffic and the unused selector are dropped
		send_item(FN_RX, 8'hFF, 1'b1);
		send_item(FN_TICK, 8'h00, 1'b0);
		send_item(FN_UNUSED, 8'hAA, 1'b1);
		// one-byte command; a command byte while waiting is dropped
		send_item(FN_CMD, 8'h00, 1'b1);
		send_item(FN_CMD, 8'hFF, 1'b1);
		reply_frame = '{8'hFF, 8'h80, 8'h7F};
		send_reply(0, 1'b0);
		// six bytes: command too long, nothing sent
		for (i = 0; i < CMD_SLOTS + 1; i++)
			send_item(FN_CMD, 8'(8'h11 * i), i == CMD_SLOTS);
		// full command, then a reply with a bad checksum
		send_item(FN_CMD, 8'hA5, 1'b0);
		send_item(FN_CMD, 8'h5A, 1'b0);
		send_item(FN_CMD, 8'h3C, 1'b0);
		send_item(FN_CMD, 8'hC3, 1'b0);
		send_item(FN_CMD, 8'h81, 1'b1);
		reply_frame = '{8'h01, 8'h02, 8'h00};
		send_reply(0, 1'b0);
		// timeout of zero behaves as one tick
		settle();
		apply_setting(2, 0, 0);
		send_item(FN_CMD, 8'h7E, 1'b1);
		send_item(FN_TICK, 8'h55, 1'b1);
		// ack mode ignores the length register
		settle();
		apply_setting(9, 1, 500);
		send_item(FN_CMD, 8'h01, 1'b1);
		reply_frame = '{ACK_FIRST, ACK_SECOND, ACK_FIRST ^ ACK_SECOND};
		send_reply(0, 1'b0);
		// length lowered while a reply is half in
		settle();
		apply_setting(5, 0, 500);
		send_item(FN_CMD, 8'h3A, 1'b1);
		reply_frame = '{8'h5C, 8'h5C};
		send_reply(0, 1'b0);
		settle();
		write_reg(REG_REPLY_LENGTH, 32'd1);
		cur_len = 1;
		reply_frame = '{8'h00};
		send_reply(0, 1'b0);

		// corner settings, then random ones
		useful_items = 0;
		run_phase(REPLY_CAP, 0, 65535, 2);
		run_phase(63, 0, 40, 2);
		run_phase(0, 0, 20, 4);
		run_phase(1, 0, 1, 4);
		run_phase(2, 1, 60, 6);
		while (useful_items < 200)
			run_phase(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 8),
				($urandom_range(0, 3) == 0) ? 1 : 0, $urandom_range(4, 120),
				$urandom_range(4, 10));

		settle();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/ucre_pkg.sv
hw/rtl/ucre_queue.sv
hw/rtl/ucre_front.sv
hw/rtl/ucre_back.sv
hw/rtl/uart_command_reply_engine.sv
tb/ucre_scoreboard.sv
tb/tb_uart_command_reply_engine.sv
